### hdl/oss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oss_pkg: shared types and constants for the segment sweep counter
// Sizes of the key chain, event and status codes, and the request and
// update records that travel between the top level and the key cells.
// ----------------------------------------------------------------------------
package oss_pkg;

  localparam int ACTIVE_DEPTH    = 64;
  localparam int COORD_BITS      = 16;
  localparam int IDX_W           = $clog2(ACTIVE_DEPTH);
  localparam int CNT_W           = $clog2(ACTIVE_DEPTH + 1);
  localparam int FUNC_W          = 2;
  localparam int STATUS_W        = 2;
  localparam int COUNT_W         = 7;
  localparam int TOTAL_W         = 32;
  localparam int COUNT_FIELD_MAX = 127;

  // event kinds; the fourth code does nothing
  localparam logic [FUNC_W-1:0] FN_START = 2'd0;
  localparam logic [FUNC_W-1:0] FN_END   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_QUERY = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // request walking down the key chain, collecting lookup results
  typedef struct packed {
    logic                         valid;
    logic [FUNC_W-1:0]            func;
    logic signed [COORD_BITS-1:0] lo;
    logic signed [COORD_BITS-1:0] hi;
    logic                         found;
    logic [IDX_W-1:0]             match_idx;
    logic                         free_found;
    logic [IDX_W-1:0]             free_idx;
    logic [CNT_W-1:0]             count;
  } token_t;

  // update broadcast to all cells when a request retires
  typedef struct packed {
    logic                         set;
    logic                         clr;
    logic [IDX_W-1:0]             idx;
    logic signed [COORD_BITS-1:0] key;
  } commit_t;

endpackage

### hdl/orthogonal_segment_sweep_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orthogonal_segment_sweep_counter: active y set and crossing counter
// Keeps the distinct y values of active horizontal segments in a chain of
// key cells and counts active values inside each vertical query range.
// ----------------------------------------------------------------------------
// Each request walks the chain of ACTIVE_DEPTH key cells, one cell per
// cycle, collecting the duplicate/match lookup, the lowest free entry and
// the range count. It is then caught in a register at the end of the chain
// and retires: the set is updated, the saturating total advances and the
// result is loaded into the output register. One request is in work at a
// time: the next request is taken the cycle after the previous one retires,
// and a request retires only when the output register has room. A stalled
// result holds the retiring request until the output frees up. The set
// starts empty after reset; no clearing pass is needed.
module orthogonal_segment_sweep_counter
  import oss_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [FUNC_W-1:0]            func,
  input  logic signed [COORD_BITS-1:0] key_y,
  input  logic signed [COORD_BITS-1:0] upper_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [COUNT_W-1:0]           match_count,
  output logic [TOTAL_W-1:0]           total_hits,
  output logic [STATUS_W-1:0]          status
);

  token_t               tok [ACTIVE_DEPTH+1];
  token_t               done;
  logic                 done_valid;
  logic                 busy;
  logic                 accept;
  logic                 retire;
  commit_t              commit;
  status_t              status_next;
  status_t              status_q;
  logic [CNT_W-1:0]     count_q;
  logic [TOTAL_W:0]     sum;
  logic [TOTAL_W-1:0]   hit_total;
  logic [TOTAL_W-1:0]   hit_total_next;
  logic [COUNT_W-1:0]   match_count_next;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign retire   = done_valid && (!out_valid || !out_stall);

  always_comb begin
    tok[0]            = '0;
    tok[0].valid      = accept;
    tok[0].func       = func;
    tok[0].lo         = key_y;
    tok[0].hi         = upper_y;
  end

  for (genvar g = 0; g < ACTIVE_DEPTH; g++) begin : g_cell
    oss_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (IDX_W'(g)),
      .commit   (commit),
      .tok_in   (tok[g]),
      .tok_out  (tok[g+1])
    );
  end

  // catch the request leaving the chain and hold it until it retires
  always_ff @(posedge clk) begin
    if (tok[ACTIVE_DEPTH].valid) begin
      done <= tok[ACTIVE_DEPTH];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_valid <= 1'b0;
      busy       <= 1'b0;
    end else begin
      if (tok[ACTIVE_DEPTH].valid) begin
        done_valid <= 1'b1;
      end else if (retire) begin
        done_valid <= 1'b0;
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (retire) begin
        busy <= 1'b0;
      end
    end
  end

  always_comb begin
    commit.set = retire && (done.func == FN_START) && !done.found && done.free_found;
    commit.clr = retire && (done.func == FN_END) && done.found;
    commit.idx = (done.func == FN_START) ? done.free_idx : done.match_idx;
    commit.key = done.lo;

    priority if (done.func == FN_START && done.found) begin
      status_next = ST_DUP;
    end else if (done.func == FN_START && !done.free_found) begin
      status_next = ST_FULL;
    end else if (done.func == FN_END && !done.found) begin
      status_next = ST_MISSING;
    end else begin
      status_next = ST_OK;
    end

    count_q = (done.func == FN_QUERY) ? done.count : '0;
    sum     = {1'b0, hit_total} + (TOTAL_W + 1)'(count_q);
    // saturate the running total
    hit_total_next = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];

    if (32'(count_q) > 32'(COUNT_FIELD_MAX)) begin
      match_count_next = COUNT_W'(COUNT_FIELD_MAX);
    end else begin
      match_count_next = COUNT_W'(count_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_total <= '0;
      out_valid <= 1'b0;
    end else begin
      if (retire) begin
        hit_total <= hit_total_next;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      match_count <= match_count_next;
      total_hits  <= hit_total_next;
      status_q    <= status_next;
    end
  end

  assign status = status_q;

endmodule

### hdl/oss_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oss_cell: one key cell of the active set chain
// Holds one y value and its valid bit, checks the passing request against
// it and registers the updated request for the next cell.
// ----------------------------------------------------------------------------
module oss_cell
  import oss_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_idx,
  input  commit_t          commit,
  input  token_t           tok_in,
  output token_t           tok_out
);

  logic signed [COORD_BITS-1:0] key;
  logic                         valid;
  token_t                       tok_q;
  token_t                       tok_next;
  logic                         hit;
  logic                         in_range;

  always_comb begin
    hit      = valid && (key == tok_in.lo);
    in_range = valid && ($signed(key) >= $signed(tok_in.lo))
                     && ($signed(key) <= $signed(tok_in.hi));
    tok_next = tok_in;
    // keep the first match and the lowest free entry
    if (!tok_in.found && hit) begin
      tok_next.found     = 1'b1;
      tok_next.match_idx = cell_idx;
    end
    if (!tok_in.free_found && !valid) begin
      tok_next.free_found = 1'b1;
      tok_next.free_idx   = cell_idx;
    end
    tok_next.count = tok_in.count + CNT_W'(in_range);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q.valid <= 1'b0;
    end else begin
      tok_q <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (commit.idx == cell_idx) begin
      if (commit.set) begin
        valid <= 1'b1;
      end else if (commit.clr) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit.set && (commit.idx == cell_idx)) begin
      key <= commit.key;
    end
  end

  assign tok_out = tok_q;

endmodule

### bench/orthogonal_segment_sweep_counter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orthogonal_segment_sweep_counter_tb: self-checking bench for the sweep counter
// Drives start, end and query events plus the unused code. The run opens with
// edge cases, then goes on to random sweeps that fill and drain the active y
// set. Each result is checked field by field against a local model of the set
// and the saturating total. Both sides of the interface idle at random.
// ----------------------------------------------------------------------------
module orthogonal_segment_sweep_counter_tb;
  import oss_pkg::*;

  localparam logic [FUNC_W-1:0] FN_NOOP = 2'd3;
  localparam logic signed [COORD_BITS-1:0] Y_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [COORD_BITS-1:0] Y_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam int RANDOM_EVENTS = 1900;
  localparam int REPORT_LIMIT  = 20;

  typedef struct {
    logic [FUNC_W-1:0]            fn;
    logic signed [COORD_BITS-1:0] lo;
    logic signed [COORD_BITS-1:0] hi;
  } sweep_event_t;

  typedef struct {
    logic [COUNT_W-1:0] count;
    logic [TOTAL_W-1:0] total;
    status_t            st;
  } sweep_result_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [FUNC_W-1:0]            func = '0;
  logic signed [COORD_BITS-1:0] key_y = '0;
  logic signed [COORD_BITS-1:0] upper_y = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [COUNT_W-1:0]           match_count;
  logic [TOTAL_W-1:0]           total_hits;
  logic [STATUS_W-1:0]          status;

  orthogonal_segment_sweep_counter dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .key_y       (key_y),
    .upper_y     (upper_y),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .match_count (match_count),
    .total_hits  (total_hits),
    .status      (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the active set and the running total
  logic signed [COORD_BITS-1:0] active_y [ACTIVE_DEPTH];
  bit                           active_live [ACTIVE_DEPTH];
  logic [TOTAL_W-1:0]           crossing_total = '0;

  sweep_event_t  sweep_events [$];
  sweep_result_t pending_results [$];
  logic signed [COORD_BITS-1:0] planned_y [$];

  int planned_events = 0;
  int events_sent    = 0;
  int results_seen   = 0;
  int error_count    = 0;
  int query_count    = 0;
  int status_hist [4] = '{0, 0, 0, 0};

  logic req_taken = 1'b0;
  int   burst_left = 1;
  int   gap_left = 0;
  int   stall_mode = 0;
  int   stall_phase = 0;

  initial begin
    for (int i = 0; i < ACTIVE_DEPTH; i++) begin
      active_y[i] = '0;
      active_live[i] = 1'b0;
    end
  end

  function automatic sweep_result_t sweep_predict(sweep_event_t ev);
    sweep_result_t      r;
    int                 hit;
    int                 free_slot;
    int                 cnt;
    logic [TOTAL_W:0]   sum;
    r.count = '0;
    r.st = ST_OK;
    hit = -1;
    free_slot = -1;
    cnt = 0;
    for (int i = 0; i < ACTIVE_DEPTH; i++) begin
      if (active_live[i] && active_y[i] == ev.lo && hit < 0) hit = i;
      if (!active_live[i] && free_slot < 0) free_slot = i;
    end
    case (ev.fn)
      FN_START: begin
        // duplicate wins over full
        if (hit >= 0) r.st = ST_DUP;
        else if (free_slot < 0) r.st = ST_FULL;
        else begin
          active_y[free_slot] = ev.lo;
          active_live[free_slot] = 1'b1;
        end
      end
      FN_END: begin
        if (hit < 0) r.st = ST_MISSING;
        else active_live[hit] = 1'b0;
      end
      FN_QUERY: begin
        for (int i = 0; i < ACTIVE_DEPTH; i++)
          if (active_live[i] && active_y[i] >= ev.lo && active_y[i] <= ev.hi) cnt++;
        sum = {1'b0, crossing_total} + (TOTAL_W + 1)'(cnt);
        crossing_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        r.count = (cnt > COUNT_FIELD_MAX) ? COUNT_W'(COUNT_FIELD_MAX) : COUNT_W'(cnt);
        query_count++;
      end
      default: ;
    endcase
    r.total = crossing_total;
    status_hist[r.st]++;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (error_count < REPORT_LIMIT)
      $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    error_count++;
  endtask

  // ---- stimulus planning; planned_y tracks what the set will hold ----
  function automatic int planned_find(logic signed [COORD_BITS-1:0] y);
    for (int i = 0; i < planned_y.size(); i++)
      if (planned_y[i] == y) return i;
    return -1;
  endfunction

  task automatic queue_event(input logic [FUNC_W-1:0] fn,
                             input logic signed [COORD_BITS-1:0] lo,
                             input logic signed [COORD_BITS-1:0] hi);
    sweep_event_t ev;
    int           idx;
    ev.fn = fn;
    ev.lo = lo;
    ev.hi = hi;
    sweep_events.push_back(ev);
    planned_events++;
    idx = planned_find(lo);
    if (fn == FN_START && idx < 0 && planned_y.size() < ACTIVE_DEPTH) planned_y.push_back(lo);
    if (fn == FN_END && idx >= 0) planned_y.delete(idx);
  endtask

  function automatic logic signed [COORD_BITS-1:0] pick_coord();
    int v;
    case ($urandom_range(0, 4))
      0, 1: v = $urandom;
      2: v = int'($urandom_range(0, 127)) - 64;
      3: case ($urandom_range(0, 3))
           0: v = Y_MIN;
           1: v = Y_MAX;
           2: v = 0;
           default: v = -1;
         endcase
      default: v = int'(Y_MAX) - int'($urandom_range(0, 31));
    endcase
    return v[COORD_BITS-1:0];
  endfunction

  function automatic logic signed [COORD_BITS-1:0] pick_live();
    return planned_y[$urandom_range(0, planned_y.size() - 1)];
  endfunction

  function automatic logic signed [COORD_BITS-1:0] pick_new();
    logic signed [COORD_BITS-1:0] y;
    y = pick_coord();
    while (planned_find(y) >= 0) y = pick_coord();
    return y;
  endfunction

  task automatic queue_query();
    logic signed [COORD_BITS-1:0] a;
    logic signed [COORD_BITS-1:0] b;
    a = pick_coord();
    b = pick_coord();
    case ($urandom_range(0, 5))
      0, 1, 2: begin
        if (planned_y.size() > 0) begin
          a = pick_live();
          b = pick_live();
        end
        if (a > b) queue_event(FN_QUERY, b, a);
        else queue_event(FN_QUERY, a, b);
      end
      3: queue_event(FN_QUERY, a, b);
      4: queue_event(FN_QUERY, Y_MIN, Y_MAX);
      default: begin
        // inverted range
        if (a < b) queue_event(FN_QUERY, b, a);
        else queue_event(FN_QUERY, a, b);
      end
    endcase
  endtask

  task automatic plan_directed();
    queue_event(FN_END, '0, '0);
    queue_event(FN_QUERY, Y_MIN, Y_MAX);
    queue_event(FN_START, Y_MIN, 16'sh1234);
    queue_event(FN_START, Y_MAX, Y_MIN);
    queue_event(FN_START, '0, Y_MAX);
    queue_event(FN_START, '1, '0);
    queue_event(FN_START, '0, '1);
    queue_event(FN_QUERY, Y_MIN, Y_MAX);
    queue_event(FN_QUERY, '0, '0);
    queue_event(FN_QUERY, Y_MAX, Y_MIN);
    queue_event(FN_QUERY, '1, '0);
    queue_event(FN_NOOP, 16'sh5555, 16'shAAAA);
    queue_event(FN_END, 16'sh3039, '0);
    queue_event(FN_END, '0, Y_MAX);
    queue_event(FN_END, '0, '0);
    queue_event(FN_QUERY, Y_MAX, Y_MAX);
    queue_event(FN_QUERY, Y_MIN, Y_MIN);
    queue_event(FN_NOOP, 16'shAAAA, 16'sh5555);
    queue_event(FN_END, Y_MIN, '0);
    queue_event(FN_END, Y_MAX, '0);
    queue_event(FN_END, '1, '0);
    queue_event(FN_QUERY, Y_MIN, Y_MAX);
  endtask

  task automatic plan_fill_and_drain();
    while (planned_y.size() < ACTIVE_DEPTH) queue_event(FN_START, pick_new(), pick_coord());
    queue_event(FN_START, pick_new(), pick_coord());
    queue_event(FN_START, pick_live(), pick_coord());
    queue_event(FN_QUERY, Y_MIN, Y_MAX);
    repeat (3) queue_query();
    repeat ($urandom_range(20, ACTIVE_DEPTH)) begin
      if (planned_y.size() > 0) queue_event(FN_END, pick_live(), pick_coord());
      if ($urandom_range(0, 7) == 0) queue_query();
    end
    queue_event(FN_END, pick_new(), pick_coord());
  endtask

  task automatic plan_mixed();
    int sel;
    repeat (20) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        if (planned_y.size() > 0 && $urandom_range(0, 4) == 0)
          queue_event(FN_START, pick_live(), pick_coord());
        else
          queue_event(FN_START, pick_coord(), pick_coord());
      end else if (sel < 65) begin
        if (planned_y.size() > 0 && $urandom_range(0, 3) != 0)
          queue_event(FN_END, pick_live(), pick_coord());
        else
          queue_event(FN_END, pick_coord(), pick_coord());
      end else if (sel < 95) begin
        queue_query();
      end else begin
        queue_event(FN_NOOP, pick_coord(), pick_coord());
      end
    end
  endtask

  // ---- request driver: bursts with random gaps ----
  always @(negedge clk) begin : request_drive
    sweep_event_t ev;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (sweep_events.size() != 0) begin
        ev = sweep_events.pop_front();
        func <= ev.fn;
        key_y <= ev.lo;
        upper_y <= ev.hi;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---- result stall: random mode, chosen anew when its phase counter runs out ----
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_phase == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_phase <= $urandom_range(50, 400);
      end else begin
        stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 1);
        default: out_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  // ---- check results, then record the request taken at this edge ----
  always @(posedge clk) begin : result_check
    sweep_result_t want;
    sweep_event_t  ev;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, total_hits", total_hits, 0);
      end else begin
        want = pending_results.pop_front();
        if (match_count !== want.count) report_mismatch("match_count", match_count, want.count);
        if (total_hits !== want.total) report_mismatch("total_hits", total_hits, want.total);
        if (status !== want.st) report_mismatch("status", status, want.st);
      end
    end
    req_taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      ev.fn = func;
      ev.lo = key_y;
      ev.hi = upper_y;
      pending_results.push_back(sweep_predict(ev));
      events_sent++;
    end
  end

  initial begin
    plan_directed();
    while (planned_events < RANDOM_EVENTS) begin
      if ($urandom_range(0, 99) < 8) plan_fill_and_drain();
      else plan_mixed();
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait (events_sent == planned_events);
    while (pending_results.size() != 0) @(posedge clk);
    // watch for stray results
    repeat (ACTIVE_DEPTH + 8) @(posedge clk);
    $display("sent %0d events, checked %0d results, %0d range queries",
             events_sent, results_seen, query_count);
    $display("outcomes: ok %0d, duplicate %0d, not found %0d, set full %0d",
             status_hist[ST_OK], status_hist[ST_DUP], status_hist[ST_MISSING],
             status_hist[ST_FULL]);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("timeout: %0d of %0d events sent, %0d results pending",
             events_sent, planned_events, pending_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### files.f
hdl/oss_pkg.sv
hdl/oss_cell.sv
hdl/orthogonal_segment_sweep_counter.sv
bench/orthogonal_segment_sweep_counter_tb.sv
